FILE: hw/rtl/u2f_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2f_pkg
// Shared types and constants of the UTF-8 to Fibonacci code transcoder.
// ----------------------------------------------------------------------------
package u2f_pkg;

	// default number of Fibonacci terms searched per code point
	localparam int FIB_TERMS_DEF = 30;

	// code point width and the largest legal code point
	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

	// width of a Fibonacci term, enough for the 32nd term
	localparam int FIB_W = 22;

	// Fibonacci terms 1, 2, 3, 5, ... (up to 32 of them)
	localparam logic [FIB_W-1:0] FIB_TAB [32] = '{
		22'd1,       22'd2,       22'd3,       22'd5,
		22'd8,       22'd13,      22'd21,      22'd34,
		22'd55,      22'd89,      22'd144,     22'd233,
		22'd377,     22'd610,     22'd987,     22'd1597,
		22'd2584,    22'd4181,    22'd6765,    22'd10946,
		22'd17711,   22'd28657,   22'd46368,   22'd75025,
		22'd121393,  22'd196418,  22'd317811,  22'd514229,
		22'd832040,  22'd1346269, 22'd2178309, 22'd3524578
	};

	// UTF-8 lead and continuation byte patterns
	localparam logic [7:0] MASK_ASCII = 8'h80;
	localparam logic [7:0] MASK_LEAD2 = 8'b11100000;
	localparam logic [7:0] PAT_LEAD2  = 8'b11000000;
	localparam logic [7:0] MASK_LEAD3 = 8'b11110000;
	localparam logic [7:0] PAT_LEAD3  = 8'b11100000;
	localparam logic [7:0] MASK_LEAD4 = 8'b11111000;
	localparam logic [7:0] PAT_LEAD4  = 8'b11110000;
	localparam logic [7:0] MASK_CONT  = 8'b11000000;
	localparam logic [7:0] PAT_CONT   = 8'b10000000;
	localparam logic [7:0] CONT_BITS  = 8'b00111111;

	// result status codes
	localparam logic [1:0] ST_CODE = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic accept;    // input transfer this cycle
		logic step;      // one Zeckendorf search step
		logic pack;      // merge code word with the partial byte
		logic emit;      // load one packed byte into the output register
		logic settle;    // keep the leftover bits as the partial byte
		logic end_step;  // load one end-of-stream result
	} u2f_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_end;     // input item is an end marker
		logic do_enc;     // input byte completes a code point
		logic srch_last;  // search is at the lowest term
		logic acc_ge8;    // a full byte is waiting in the merge register
		logic out_free;   // output register can take a result
		logic end_done;   // the next end result is the final one
	} u2f_sts_t;

endpackage

FILE: hw/rtl/u2f_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2f_ctrl
// Sequencer: accept, Fibonacci search, pack, byte emission, end of stream.
// ----------------------------------------------------------------------------
module u2f_ctrl
	import u2f_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  u2f_sts_t sts,
	output u2f_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_PACK = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_END  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.is_end) begin
						state_nxt = S_END;
					end else if (sts.do_enc) begin
						state_nxt = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				cmd.step = 1'b1;
				if (sts.srch_last) begin
					state_nxt = S_PACK;
				end
			end
			S_PACK: begin
				cmd.pack  = 1'b1;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (sts.acc_ge8) begin
					cmd.emit = sts.out_free;
				end else begin
					cmd.settle = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.end_step = 1'b1;
					if (sts.end_done) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: hw/rtl/u2f_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2f_dp
// Datapath: UTF-8 decode, Zeckendorf search, bit packer, output register.
// ----------------------------------------------------------------------------
module u2f_dp
	import u2f_pkg::*;
#(
	parameter int FIB_TERMS = FIB_TERMS_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  u2f_cmd_t   cmd,
	output u2f_sts_t   sts,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       last
);

	localparam int IDXW = $clog2(FIB_TERMS);
	localparam int CODEW = FIB_TERMS + 1;
	localparam int ACCW = FIB_TERMS + 8;
	localparam int LENW = $clog2(ACCW + 1);

	// decoder and packer state
	logic [CP_W-1:0] accum_q;
	logic [1:0]      pend_q;
	logic            failed_q;
	logic [7:0]      pack_byte_q;
	logic [2:0]      pack_cnt_q;

	// search and merge registers
	logic [CP_W-1:0]      n_q;
	logic [IDXW-1:0]      idx_q;
	logic [IDXW-1:0]      top_q;
	logic                 hit_q;
	logic [FIB_TERMS-1:0] bits_q;
	logic [ACCW-1:0]      acc_q;
	logic [LENW-1:0]      acc_len_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] status_q;
	logic       last_q;

	logic [CP_W-1:0] nxt_accum;
	logic [1:0]      nxt_pend;
	logic            nxt_fail;
	logic            dec_enc;
	logic [CP_W-1:0] dec_cp;
	logic [CP_W-1:0] cont_acc;
	logic [1:0]      pend_dec;

	logic [FIB_W-1:0] fib_cur;
	logic             fib_hit;
	logic [IDXW:0]    term_pos;
	logic [CODEW-1:0] code_w;
	logic             end_fail;
	logic             out_free;
	logic             out_load;

	// --- UTF-8 decode ---
	assign cont_acc = {accum_q[CP_W-7:0], data_byte[5:0]};
	assign pend_dec = pend_q - 2'd1;

	always_comb begin
		nxt_accum = accum_q;
		nxt_pend  = pend_q;
		nxt_fail  = failed_q;
		dec_enc   = 1'b0;
		dec_cp    = '0;
		if (!failed_q) begin
			if (pend_q == 2'd0) begin
				if ((data_byte & MASK_ASCII) == 8'd0) begin
					dec_enc = 1'b1;
					dec_cp  = CP_W'(data_byte[6:0]);
				end else if ((data_byte & MASK_LEAD2) == PAT_LEAD2) begin
					nxt_accum = CP_W'(data_byte[4:0]);
					nxt_pend  = 2'd1;
				end else if ((data_byte & MASK_LEAD3) == PAT_LEAD3) begin
					nxt_accum = CP_W'(data_byte[3:0]);
					nxt_pend  = 2'd2;
				end else if ((data_byte & MASK_LEAD4) == PAT_LEAD4) begin
					nxt_accum = CP_W'(data_byte[2:0]);
					nxt_pend  = 2'd3;
				end else begin
					nxt_fail = 1'b1;
				end
			end else if ((data_byte & MASK_CONT) != PAT_CONT) begin
				nxt_fail = 1'b1;
			end else begin
				nxt_accum = cont_acc;
				nxt_pend  = pend_dec;
				if (pend_dec == 2'd0) begin
					nxt_accum = '0;
					if (cont_acc > CP_MAX) begin
						nxt_fail = 1'b1;
					end else begin
						dec_enc = 1'b1;
						dec_cp  = cont_acc;
					end
				end
			end
		end
	end

	// --- search and merge ---
	assign fib_cur  = FIB_TAB[idx_q];
	assign fib_hit  = (fib_cur <= FIB_W'(n_q));
	// terminating 1 sits just above the highest term used
	assign term_pos = {1'b0, top_q} + (IDXW+1)'(1);
	assign code_w   = CODEW'(bits_q) | (CODEW'(1) << term_pos);

	assign end_fail = failed_q || (pend_q != 2'd0);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = cmd.emit || cmd.end_step;

	always_comb begin
		sts.is_end    = kind;
		sts.do_enc    = !kind && dec_enc;
		sts.srch_last = (idx_q == '0);
		sts.acc_ge8   = (acc_len_q >= LENW'(8));
		sts.out_free  = out_free;
		sts.end_done  = end_fail || (pack_cnt_q == 3'd0);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			pend_q      <= 2'd0;
			failed_q    <= 1'b0;
			pack_byte_q <= 8'd0;
			pack_cnt_q  <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && !kind) begin
				accum_q  <= nxt_accum;
				pend_q   <= nxt_pend;
				failed_q <= nxt_fail;
			end
			if (cmd.settle) begin
				pack_byte_q <= acc_q[7:0];
				pack_cnt_q  <= acc_len_q[2:0];
			end
			if (cmd.end_step) begin
				pack_byte_q <= 8'd0;
				pack_cnt_q  <= 3'd0;
				if (end_fail || (pack_cnt_q == 3'd0)) begin
					accum_q  <= '0;
					pend_q   <= 2'd0;
					failed_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.do_enc) begin
			n_q    <= dec_cp + CP_W'(1);
			idx_q  <= IDXW'(FIB_TERMS - 1);
			hit_q  <= 1'b0;
			top_q  <= '0;
			bits_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q - IDXW'(1);
			if (fib_hit) begin
				n_q           <= n_q - fib_cur[CP_W-1:0];
				bits_q[idx_q] <= 1'b1;
				if (!hit_q) begin
					top_q <= idx_q;
					hit_q <= 1'b1;
				end
			end
		end
		if (cmd.pack) begin
			acc_q     <= (ACCW'(code_w) << pack_cnt_q) | ACCW'(pack_byte_q);
			acc_len_q <= LENW'(pack_cnt_q) + LENW'(top_q) + LENW'(2);
		end else if (cmd.emit) begin
			acc_q     <= acc_q >> 8;
			acc_len_q <= acc_len_q - LENW'(8);
		end
		if (cmd.emit) begin
			out_byte_q <= acc_q[7:0];
			status_q   <= ST_CODE;
			last_q     <= (acc_len_q < LENW'(16));
		end else if (cmd.end_step) begin
			if (end_fail) begin
				out_byte_q <= 8'd0;
				status_q   <= ST_FAIL;
				last_q     <= 1'b1;
			end else if (pack_cnt_q != 3'd0) begin
				out_byte_q <= pack_byte_q;
				status_q   <= ST_CODE;
				last_q     <= 1'b0;
			end else begin
				out_byte_q <= 8'd0;
				status_q   <= ST_OK;
				last_q     <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

	// a result is never loaded over one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded while output register busy");

	// greedy search must consume the whole value
	a_search_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && idx_q == '0) |=> (n_q == '0))
		else $error("Zeckendorf remainder not zero");

	// leftover bits kept as the partial byte fit in it
	a_settle_short: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.settle |-> (acc_len_q < LENW'(8)))
		else $error("settling with a full byte left");

	// final end result leaves the stream state cleared
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.end_step && sts.end_done) |=>
			(!failed_q && pend_q == 2'd0 && pack_cnt_q == 3'd0))
		else $error("stream state not cleared at end");

endmodule

FILE: hw/rtl/utf8_to_fibonacci_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_fibonacci_transcoder
// UTF-8 byte stream in, packed Fibonacci (Zeckendorf) code bytes out.
// ----------------------------------------------------------------------------
// The block takes one item per input transfer: a UTF-8 byte (kind = 0) or an
// end-of-stream marker (kind = 1). Bytes that only open or extend a sequence
// give no result. A byte that completes a code point runs the greedy
// Zeckendorf search, one Fibonacci term per cycle through a single compare
// and subtract over FIB_TERMS terms, then packs the code and emits its
// output bytes (0 to 4 of them, held back while the output side stalls).
// An end marker gives one or two result transfers. Overlong forms and
// surrogates pass; a bad lead, a bad continuation or a value above 0x10FFFF
// makes the stream fail, later bytes are dropped, and the end marker then
// reports status 2 without flushing. A good end flushes any partial byte
// (status 0) and reports status 1. The flag last marks the final result of
// each input item. An end inside an open sequence also reports status 2.
// The block is back to its reset state after every end.
// ----------------------------------------------------------------------------
module utf8_to_fibonacci_transcoder
	import u2f_pkg::*;
#(
	parameter int FIB_TERMS = FIB_TERMS_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       last
);

	// command and status between sequencer and datapath
	u2f_cmd_t cmd;
	u2f_sts_t sts;

	// sequencer: holds off input transfers while a code point is encoded or an end is reported
	u2f_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: decoder state, term search, bit packer and output register
	u2f_dp #(
		.FIB_TERMS (FIB_TERMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);

endmodule

FILE: tb/utf8_to_fibonacci_transcoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 to Fibonacci code transcoder.
// ----------------------------------------------------------------------------
// A queue of pending items is filled up front: a directed set of UTF-8 corner
// cases (extreme code points, overlong forms, surrogates, every failure kind,
// truncated sequences, empty stream), then random streams of well-formed
// characters with some noise and broken sequences mixed in. A clocked driver
// feeds the queue to the block with random gaps. Every accepted transfer runs
// through a bit-accurate predictor that fills the queue of expected code
// bytes. A clocked monitor stalls the result channel at random and compares
// each result transfer field by field against the oldest expected entry.
// ----------------------------------------------------------------------------
module testbench;
	import u2f_pkg::*;

	localparam int FIB_COUNT = FIB_TERMS_DEF;

	// input item kinds
	localparam bit KIND_DATA = 1'b0;
	localparam bit KIND_END  = 1'b1;

	// long receiver hold-off, in cycles, started once enough items went in
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 150;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} code_result_t;

	typedef struct {
		bit       kind;
		bit [7:0] data;
		bit       drain_first;  // wait until all expected results are in
	} feed_item_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic       kind      = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	feed_item_t   feed_q [$];
	code_result_t expected_codes [$];
	code_result_t step_out [$];

	// predictor state
	logic [20:0] cp_accum;
	int          cont_left;
	logic [7:0]  bit_buf;
	int          bit_cnt;
	bit          stream_bad;

	int  items_sent = 0;
	int  errors     = 0;
	int  gap_left   = 0;
	bit  in_calm    = 1'b0;
	int  stall_left = 0;
	bit  out_calm   = 1'b0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;

	utf8_to_fibonacci_transcoder #(
		.FIB_TERMS (FIB_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	task automatic clear_stream();
		cp_accum   = '0;
		cont_left  = 0;
		bit_buf    = '0;
		bit_cnt    = 0;
		stream_bad = 1'b0;
	endtask

	task automatic emit_result(logic [7:0] b, logic [1:0] st);
		code_result_t r;
		r.out_byte = b;
		r.status   = st;
		r.last     = 1'b0;
		step_out.push_back(r);
	endtask

	// one code bit into the partial byte, LSB first
	task automatic pack_bit(logic b);
		bit_buf[bit_cnt] = b;
		bit_cnt++;
		if (bit_cnt == 8) begin
			emit_result(bit_buf, ST_CODE);
			bit_buf = '0;
			bit_cnt = 0;
		end
	endtask

	// Zeckendorf code of cp + 1, lowest term first, closed by an extra 1
	task automatic zeck_encode(logic [20:0] cp);
		logic [31:0] fib [FIB_COUNT];
		logic [31:0] rest;
		logic [FIB_COUNT-1:0] used;
		int top;
		fib[0] = 32'd1;
		fib[1] = 32'd2;
		for (int i = 2; i < FIB_COUNT; i++)
			fib[i] = fib[i-1] + fib[i-2];
		rest = 32'(cp) + 32'd1;
		used = '0;
		top  = -1;
		for (int i = FIB_COUNT - 1; i >= 0; i--) begin
			if (fib[i] <= rest) begin
				if (top < 0)
					top = i;
				used[i] = 1'b1;
				rest    = rest - fib[i];
			end
		end
		for (int i = 0; i <= top; i++)
			pack_bit(used[i]);
		pack_bit(1'b1);
	endtask

	task automatic transcode_item(bit k, logic [7:0] b);
		step_out.delete();
		if (k == KIND_END) begin
			if (stream_bad || cont_left != 0) begin
				emit_result(8'h00, ST_FAIL);
			end else begin
				if (bit_cnt > 0)
					emit_result(bit_buf, ST_CODE);
				emit_result(8'h00, ST_OK);
			end
			clear_stream();
		end else if (!stream_bad) begin
			if (cont_left == 0) begin
				if ((b & MASK_ASCII) == 8'h00) begin
					zeck_encode({14'd0, b[6:0]});
				end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
					cp_accum  = {16'd0, b[4:0]};
					cont_left = 1;
				end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
					cp_accum  = {17'd0, b[3:0]};
					cont_left = 2;
				end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
					cp_accum  = {18'd0, b[2:0]};
					cont_left = 3;
				end else begin
					stream_bad = 1'b1;  // stray continuation or 11111xxx lead
				end
			end else if ((b & MASK_CONT) != PAT_CONT) begin
				stream_bad = 1'b1;
			end else begin
				cp_accum  = {cp_accum[14:0], b[5:0]};
				cont_left = cont_left - 1;
				if (cont_left == 0) begin
					if (cp_accum > CP_MAX)
						stream_bad = 1'b1;
					else
						zeck_encode(cp_accum);
					cp_accum = '0;
				end
			end
		end
		if (step_out.size() > 0)
			step_out[step_out.size()-1].last = 1'b1;
		foreach (step_out[i])
			expected_codes.push_back(step_out[i]);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic feed_raw(bit k, bit [7:0] d, bit drain);
		feed_item_t it;
		it.kind        = k;
		it.data        = d;
		it.drain_first = drain;
		feed_q.push_back(it);
	endtask

	task automatic feed_byte(bit [7:0] d);
		feed_raw(KIND_DATA, d, 1'b0);
	endtask

	task automatic feed_end(bit drain);
		feed_raw(KIND_END, 8'h00, drain);
	endtask

	// UTF-8 form of cp in len bytes (overlong allowed); only the first keep
	// bytes go out, so keep < len gives a truncated sequence
	task automatic feed_char(int len, logic [20:0] cp, int keep);
		bit [7:0] seq [4];
		case (len)
			1: begin
				seq[0] = {1'b0, cp[6:0]};
			end
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			feed_byte(seq[i]);
	endtask

	// random stream: mostly well-formed characters, some noise, then an end
	task automatic feed_stream();
		int n_chars;
		int roll;
		int len;
		int keep;
		logic [20:0] cp;
		n_chars = $urandom_range(1, 8);
		if ($urandom_range(0, 9) == 0)
			feed_raw(KIND_DATA, 8'($urandom_range(0, 127)), 1'b1);
		for (int c = 0; c < n_chars; c++) begin
			roll = $urandom_range(0, 99);
			len  = $urandom_range(1, 4);
			case (len)
				1: cp = 21'($urandom_range(0, 'h7F));
				2: cp = 21'($urandom_range(0, 'h7FF));
				3: cp = 21'($urandom_range(0, 'hFFFF));
				default: begin
					if ($urandom_range(0, 9) == 0)
						cp = 21'($urandom_range(0, 'h1FFFFF));
					else
						cp = 21'($urandom_range(0, 'h10FFFF));
				end
			endcase
			keep = len;
			if (roll < 4) begin
				feed_byte(8'($urandom_range(0, 255)));
			end else if (roll < 6) begin
				feed_raw(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
			end else begin
				if (roll < 9 && len > 1)
					keep = $urandom_range(1, len - 1);
				feed_char(len, cp, keep);
			end
		end
		feed_end(1'b0);
	endtask

	function automatic int idle_len(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Driver: presents queued items, runs the predictor on every transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		feed_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				transcode_item(kind, data_byte);
				items_sent++;
			end
			// a stalled item stays on the bus untouched
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (feed_q.size() > 0 &&
						!(feed_q[0].drain_first && expected_codes.size() > 0)) begin
					nxt = feed_q.pop_front();
					kind      <= nxt.kind;
					data_byte <= nxt.data;
					in_valid  <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						in_calm = !in_calm;
					gap_left = idle_len(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks result transfers, drives out_stall
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		code_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected result: out_byte %02h status %0d last %0b",
						out_byte, status, last);
					errors++;
				end else begin
					want = expected_codes.pop_front();
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, actual %02h", want.out_byte, out_byte);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						errors++;
					end
				end
			end
			// one long hold-off so the block backs up into its input
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && items_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 59) == 0)
					out_calm = !out_calm;
				stall_left = idle_len(out_calm);
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		int target;
		clear_stream();

		// extreme code points, overlong, surrogate, then a good end with flush
		feed_byte(8'h00);
		feed_byte(8'h7F);
		feed_byte(8'hC0); feed_byte(8'h80);                   // overlong NUL
		feed_byte(8'hED); feed_byte(8'hA0); feed_byte(8'h80); // surrogate
		feed_byte(8'hF4); feed_byte(8'h8F);
		feed_byte(8'hBF); feed_byte(8'hBF);                   // 0x10FFFF
		feed_end(1'b0);
		// above the code space
		feed_byte(8'hF4); feed_byte(8'h90);
		feed_byte(8'h80); feed_byte(8'h80);
		feed_end(1'b0);
		// stray continuation as a lead, then a 11111xxx byte that is dropped
		feed_byte(8'h80);
		feed_byte(8'hFF);
		feed_end(1'b0);
		// bad continuation
		feed_byte(8'hC2); feed_byte(8'h41);
		feed_end(1'b0);
		// sequence cut short by the end marker
		feed_byte(8'hE2); feed_byte(8'h82);
		feed_end(1'b0);
		// empty stream, sent only once the block has drained
		feed_end(1'b1);

		target = feed_q.size() + 420;
		while (feed_q.size() < target)
			feed_stream();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// sampled mid-cycle, once the driver and monitor have settled
		while (feed_q.size() != 0 || in_valid || expected_codes.size() != 0)
			@(negedge clk);
		repeat (64) @(posedge clk);

		if (errors == 0)
			$display("utf8_to_fibonacci_transcoder: match");
		else
			$display("utf8_to_fibonacci_transcoder: mismatch");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("utf8_to_fibonacci_transcoder: mismatch");
		$finish;
	end

endmodule

FILE: utf8_to_fibonacci_transcoder.f
hw/rtl/u2f_pkg.sv
hw/rtl/u2f_ctrl.sv
hw/rtl/u2f_dp.sv
hw/rtl/utf8_to_fibonacci_transcoder.sv
tb/utf8_to_fibonacci_transcoder_tb.sv
